### rtl/core/ppct_pkg.sv
// ----------------------------------------------------------------------------
// Probe packet counter table package
// Shared field widths, constants and the controller state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppct_pkg;

    localparam int ID_W   = 63;
    localparam int TOT_W  = 14;
    localparam int CODE_W = 27;
    localparam int WIN_W  = 32;

    localparam logic [TOT_W-1:0] COUNT_MAX   = 14'd9999;
    localparam logic [WIN_W-1:0] STALE_RESET = 32'd20000000;
    localparam int               CODE_SCALE  = 10000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_CHECK,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

### rtl/core/ppct_if.sv
// ----------------------------------------------------------------------------
// Probe packet counter table channels
// Valid/ready interfaces for the packet input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppct_in_if;
    logic                       valid;
    logic                       ready;
    logic [ppct_pkg::ID_W-1:0]  packet_id;
    logic [ppct_pkg::TOT_W-1:0] total_packets;

    modport source (output valid, output packet_id, output total_packets, input ready);
    modport sink   (input valid, input packet_id, input total_packets, output ready);
endinterface

interface ppct_out_if;
    logic                        valid;
    logic                        ready;
    logic [ppct_pkg::CODE_W-1:0] sequence_code;
    logic [ppct_pkg::TOT_W-1:0]  received_count;

    modport source (output valid, output sequence_code, output received_count, input ready);
    modport sink   (input valid, input sequence_code, input received_count, output ready);
endinterface

`default_nettype wire

### rtl/core/ppct_ram.sv
// ----------------------------------------------------------------------------
// Probe packet counter table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/ppct_home.sv
// ----------------------------------------------------------------------------
// Probe packet counter table home slot unit
// Reduces a packet ID modulo the table depth: a bit select for a power of
// two, otherwise a fold of the upper ID bits into 32 bits followed by a
// reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppct_home #(
    parameter int DEPTH = 2048
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [ppct_pkg::ID_W-1:0] i_id,
    output logic                      o_done,
    output logic [$clog2(DEPTH)-1:0]  o_home
);

    localparam int AW = $clog2(DEPTH);

    generate
        if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
            logic          r_done;
            logic [AW-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
                if (i_start) begin
                    r_home <= i_id[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_fold
            localparam int          XW     = ppct_pkg::ID_W;
            localparam int          SH     = 32 + AW;
            localparam logic [63:0] DEP64  = 64'(DEPTH);
            localparam logic [15:0] FOLD_K = 16'((64'd1 << 32) % DEP64);
            localparam logic [33:0] RECIP  = 34'(((64'd1 << SH) + DEP64 - 64'd1) / DEP64);

            logic          r_fold;
            logic          r_rem_step;
            logic          r_done;
            logic [XW-1:0] r_x;
            logic [31:0]   r_q;
            logic [AW-1:0] r_home;
            logic [47:0]   w_fold_prod;
            logic [XW-1:0] w_folded;
            logic [65:0]   w_q_prod;
            logic [31:0]   w_qd;
            logic [31:0]   w_rem;

            // fold bits above 31 back in with 2^32 mod depth
            assign w_fold_prod = 48'(r_x[XW-1:32]) * 48'(FOLD_K);
            assign w_folded    = XW'(w_fold_prod) + XW'(r_x[31:0]);
            assign w_q_prod    = 66'(r_x[31:0]) * 66'(RECIP);
            assign w_qd        = r_q * 32'(DEPTH);
            assign w_rem       = r_x[31:0] - w_qd;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_fold     <= 1'b0;
                    r_rem_step <= 1'b0;
                    r_done     <= 1'b0;
                end else if (i_start) begin
                    r_fold     <= 1'b1;
                    r_rem_step <= 1'b0;
                    r_done     <= 1'b0;
                end else if (r_fold) begin
                    if (r_x[XW-1:32] == '0) begin
                        r_fold     <= 1'b0;
                        r_rem_step <= 1'b1;
                    end
                end else if (r_rem_step) begin
                    r_rem_step <= 1'b0;
                    r_done     <= 1'b1;
                end
                if (i_start) begin
                    r_x <= i_id;
                end else if (r_fold && (r_x[XW-1:32] != '0)) begin
                    r_x <= w_folded;
                end
                if (r_fold) begin
                    r_q <= 32'(w_q_prod >> SH);
                end
                if (r_rem_step) begin
                    r_home <= w_rem[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end
    endgenerate

endmodule

`default_nettype wire

### rtl/core/probe_packet_counter_table.sv
// ----------------------------------------------------------------------------
// Probe packet counter table
// Counts probe packets per measurement ID in a linearly probed hash table
// held in one RAM of {id, count} entries.
// ----------------------------------------------------------------------------
//  channel   direction  beat
//  i_in      in         packet_id, total_packets
//  o_out     out        sequence_code, received_count
//  i_cfg     in         stale window register write
//
//  A packet reads one RAM slot per probe; a depth that is not a power of two
//  finds the home slot by folding and a reciprocal multiplication.
//  Reset runs a clearing pass of TABLE_DEPTH cycles before the first packet.
//  A stalled output holds the table write and the result in the write step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module probe_packet_counter_table #(
    parameter int TABLE_DEPTH = 2048
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    ppct_in_if.sink                    i_in,
    ppct_out_if.source                 o_out,
    input  wire                        i_cfg_wr_en,
    input  wire  [ppct_pkg::WIN_W-1:0] i_cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = ppct_pkg::ID_W;
    localparam int TW = ppct_pkg::TOT_W;
    localparam int DW = IW + TW;

    ppct_pkg::t_state r_state, n_state;

    logic [AW-1:0]                  r_clr_addr;
    logic [IW-1:0]                  r_id;
    logic [TW-1:0]                  r_tot;
    logic [AW-1:0]                  r_home;
    logic [AW-1:0]                  r_idx;
    logic [AW-1:0]                  r_steps;
    logic [ppct_pkg::WIN_W-1:0]     r_window;
    logic                           r_wr_en;
    logic [IW-1:0]                  r_wr_id;
    logic [TW-1:0]                  r_wr_cnt;
    logic                           r_out_valid;
    logic [ppct_pkg::CODE_W-1:0]    r_code;
    logic [TW-1:0]                  r_count;

    logic                           w_accept;
    logic                           w_in_zero;
    logic [TW-1:0]                  w_tot_clamp;
    logic                           w_home_done;
    logic [AW-1:0]                  w_home;
    logic                           w_out_free;

    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr;
    logic [DW-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [DW-1:0]                  ram_rd_data;

    logic [IW-1:0]                  w_slot_id;
    logic [TW-1:0]                  w_slot_cnt;
    logic [IW:0]                    w_diff;
    logic [IW-1:0]                  w_dist;
    logic                           w_hit;
    logic                           w_ended;
    logic                           w_full;
    logic [TW-1:0]                  w_inc;
    logic [AW-1:0]                  w_next_idx;
    logic [ppct_pkg::CODE_W:0]      w_prod;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_in_zero   = (i_in.packet_id == '0);
    assign w_tot_clamp = (i_in.total_packets > ppct_pkg::COUNT_MAX) ? ppct_pkg::COUNT_MAX
                                                                    : i_in.total_packets;
    assign w_out_free  = !r_out_valid || o_out.ready;

    ppct_home #(
        .DEPTH (TABLE_DEPTH)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_id    (i_in.packet_id),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    ppct_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // probe step evaluation on the slot read last cycle
    assign w_slot_id  = ram_rd_data[DW-1:TW];
    assign w_slot_cnt = ram_rd_data[TW-1:0];
    assign w_diff     = {1'b0, r_id} - {1'b0, w_slot_id};
    assign w_dist     = w_diff[IW] ? (w_slot_id - r_id) : w_diff[IW-1:0];
    assign w_hit      = (w_slot_id == r_id);
    assign w_ended    = w_hit || (w_slot_id == '0) || (w_dist[IW-1:ppct_pkg::WIN_W] != '0)
                        || (w_dist[ppct_pkg::WIN_W-1:0] >= r_window);
    assign w_full     = (r_steps == AW'(TABLE_DEPTH - 1));
    assign w_inc      = (w_slot_cnt < ppct_pkg::COUNT_MAX) ? (w_slot_cnt + 1'b1)
                                                            : ppct_pkg::COUNT_MAX;
    assign w_next_idx = (r_idx == AW'(TABLE_DEPTH - 1)) ? '0 : (r_idx + 1'b1);
    assign w_prod     = (ppct_pkg::CODE_W + 1)'(r_tot) * (ppct_pkg::CODE_W + 1)'(ppct_pkg::CODE_SCALE)
                        + (ppct_pkg::CODE_W + 1)'(r_wr_cnt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppct_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ppct_pkg::ST_IDLE;
                end
            end
            ppct_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_zero ? ppct_pkg::ST_WRITE : ppct_pkg::ST_HOME;
                end
            end
            ppct_pkg::ST_HOME: begin
                if (w_home_done) begin
                    n_state = ppct_pkg::ST_CHECK;
                end
            end
            ppct_pkg::ST_CHECK: begin
                if (w_ended || w_full) begin
                    n_state = ppct_pkg::ST_WRITE;
                end
            end
            ppct_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ppct_pkg::ST_IDLE;
                end
            end
            default: n_state = ppct_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = {r_wr_id, r_wr_cnt};
        ram_rd_en   = 1'b0;
        ram_rd_addr = w_next_idx;
        case (r_state)
            ppct_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            ppct_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ppct_pkg::ST_HOME: begin
                ram_rd_en   = w_home_done;
                ram_rd_addr = w_home;
            end
            ppct_pkg::ST_CHECK: begin
                ram_rd_en = !(w_ended || w_full);
            end
            ppct_pkg::ST_WRITE: begin
                ram_wr_en = w_out_free && r_wr_en;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppct_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_window    <= ppct_pkg::STALE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ppct_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (r_state == ppct_pkg::ST_WRITE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id     <= i_in.packet_id;
            r_tot    <= w_tot_clamp;
            r_wr_en  <= 1'b0;
            r_wr_cnt <= TW'(1);
        end
        if (r_state == ppct_pkg::ST_HOME && w_home_done) begin
            r_home  <= w_home;
            r_idx   <= w_home;
            r_steps <= '0;
        end
        if (r_state == ppct_pkg::ST_CHECK) begin
            if (w_ended) begin
                r_wr_en <= 1'b1;
                if (w_hit) begin
                    r_wr_id  <= (w_inc == r_tot) ? '0 : r_id;
                    r_wr_cnt <= w_inc;
                end else begin
                    r_wr_id  <= r_id;
                    r_wr_cnt <= TW'(1);
                end
            end else if (w_full) begin
                // full circle: claim home
                r_wr_en  <= 1'b1;
                r_idx    <= r_home;
                r_wr_id  <= r_id;
                r_wr_cnt <= TW'(1);
            end else begin
                r_idx   <= w_next_idx;
                r_steps <= r_steps + 1'b1;
            end
        end
        if (r_state == ppct_pkg::ST_WRITE && w_out_free) begin
            r_code  <= w_prod[ppct_pkg::CODE_W-1:0];
            r_count <= r_wr_cnt;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sequence_code  = r_code;
    assign o_out.received_count = r_count;

endmodule

`default_nettype wire

### sim/probe_packet_counter_table_tb.sv
// ----------------------------------------------------------------------------
// Probe packet counter table testbench
// Drives packet beats in random bursts against a receiver that stalls on its
// own pattern. An internal copy of the slot table predicts every count and
// sequence code, and each result beat is checked in order. Covered: zero IDs,
// clamped totals, measurement completion, collision chains, stale slots,
// window extremes and long stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module probe_packet_counter_table_tb;

    localparam int ID_W   = ppct_pkg::ID_W;
    localparam int TOT_W  = ppct_pkg::TOT_W;
    localparam int CODE_W = ppct_pkg::CODE_W;
    localparam int WIN_W  = ppct_pkg::WIN_W;

    localparam logic [TOT_W-1:0] COUNT_MAX   = ppct_pkg::COUNT_MAX;
    localparam logic [WIN_W-1:0] STALE_RESET = ppct_pkg::STALE_RESET;
    localparam int               CODE_SCALE  = ppct_pkg::CODE_SCALE;

    localparam int DEPTH       = 2048;
    localparam int LONG_STALL  = 400;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [ID_W-1:0] ID_MAX       = {ID_W{1'b1}};
    localparam logic [WIN_W-1:0] WINDOW_MAX  = {WIN_W{1'b1}};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TOT_W-1:0]  count;
    } t_tally;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [WIN_W-1:0] i_cfg_wr_data;

    ppct_in_if  pkt ();
    ppct_out_if tally ();

    probe_packet_counter_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (pkt),
        .o_out         (tally),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    logic [ID_W-1:0]  slot_id_copy  [DEPTH];
    logic [TOT_W-1:0] slot_cnt_copy [DEPTH];
    logic [WIN_W-1:0] window_copy;

    t_tally due_tallies[$];

    int mismatches;
    int packets_sent;
    int tallies_checked;
    int windows_set;
    int full_circles;
    int cycle_count;
    int burst_left;
    int stall_requests;
    int stall_served;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, due_tallies.size());
        $display("probe_packet_counter_table_tb failed");
        $finish;
    end

    function automatic void count_packet(input logic [ID_W-1:0] id,
                                         input logic [TOT_W-1:0] tot_in,
                                         output t_tally res);
        logic [TOT_W-1:0] tot;
        logic [TOT_W-1:0] cnt;
        logic [ID_W-1:0]  occupant;
        logic [ID_W-1:0]  span;
        int               home;
        int               idx;
        int               steps;
        bit               ended;
        tot = (tot_in > COUNT_MAX) ? COUNT_MAX : tot_in;
        cnt = 1;
        if (id != '0) begin
            home  = int'(id % ID_W'(DEPTH));
            idx   = home;
            steps = 0;
            ended = 1'b0;
            while (!ended && steps < DEPTH) begin
                occupant = slot_id_copy[idx];
                span = (id >= occupant) ? id - occupant : occupant - id;
                if (occupant == id || occupant == '0 || span >= ID_W'(window_copy)) begin
                    ended = 1'b1;
                end else begin
                    idx = (idx + 1) % DEPTH;
                    steps++;
                end
            end
            if (!ended) begin
                idx = home;
                full_circles++;
            end
            if (ended && slot_id_copy[idx] == id) begin
                cnt = slot_cnt_copy[idx];
                if (cnt < COUNT_MAX) cnt = cnt + 1'b1;
                slot_cnt_copy[idx] = cnt;
                if (cnt == tot) slot_id_copy[idx] = '0;
            end else begin
                slot_id_copy[idx]  = id;
                slot_cnt_copy[idx] = 1;
                cnt = 1;
            end
        end
        res.count = cnt;
        res.code  = CODE_W'(32'(tot) * 32'(CODE_SCALE) + 32'(cnt));
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_packet(input logic [ID_W-1:0] id, input logic [TOT_W-1:0] tot);
        int     gap;
        t_tally res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge i_clk);
                pkt.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        pkt.valid         = 1'b1;
        pkt.packet_id     = id;
        pkt.total_packets = tot;
        do @(posedge i_clk); while (!pkt.ready);
        count_packet(id, tot, res);
        due_tallies.push_back(res);
        packets_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        pkt.valid = 1'b0;
        burst_left = 0;
        while (due_tallies.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = w;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = $urandom;
        window_copy = w;
        windows_set++;
    endtask

    // Receiver: own stall pattern, plus long holds on request.
    initial begin
        int mode;
        int mode_left;
        int beat_phase;
        tally.ready = 1'b0;
        mode_left  = 0;
        beat_phase = 0;
        mode       = 0;
        forever begin
            @(negedge i_clk);
            if (stall_requests != stall_served) begin
                stall_served++;
                tally.ready = 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            beat_phase = (beat_phase + 1) % 7;
            case (mode)
                0: begin
                    tally.ready = 1'b1;
                end
                1: begin
                    tally.ready = $urandom_range(0, 1);
                end
                default: begin
                    tally.ready = (beat_phase < 4);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && tally.valid && tally.ready) begin
            if (due_tallies.size() == 0) begin
                $display("%0t: unexpected result code %0d count %0d", $time,
                         tally.sequence_code, tally.received_count);
                mismatches++;
            end else begin
                want = due_tallies.pop_front();
                tallies_checked++;
                if (tally.sequence_code !== want.code) begin
                    $display("%0t: sequence_code expected %0d actual %0d", $time,
                             want.code, tally.sequence_code);
                    mismatches++;
                end
                if (tally.received_count !== want.count) begin
                    $display("%0t: received_count expected %0d actual %0d", $time,
                             want.count, tally.received_count);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        set_window(STALE_RESET);
        send_packet('0, 14'd5);
        send_packet('0, 14'd0);
        send_packet(ID_MAX, 14'd1);
        send_packet(ID_MAX, 14'd1);
        send_packet(ID_MAX, 14'd16383);
        send_packet(63'd12345, 14'd2);
        send_packet(63'd12345, 14'd2);
        send_packet(63'd12345, 14'd2);
        send_packet(63'd777, 14'd10000);
        send_packet(63'd777, 14'd16383);
        send_packet(63'd1, 14'd9999);
        send_packet(63'd1, 14'd0);
        send_packet(63'd5, 14'd3);
        send_packet(63'd5 + 63'd2048, 14'd3);
        send_packet(63'd5 + 63'd4096, 14'd3);
        send_packet(63'd5 + 63'd2048, 14'd3);
        send_packet(63'd5 + 63'd2048, 14'd3);
        send_packet(63'd5 + 63'd2048 * 63'd20000, 14'd4);
        send_packet(63'd5, 14'd3);
        send_packet(63'd2047, 14'd2);
        send_packet(63'd2047 + 63'd2048, 14'd2);
        send_packet(63'd2047 + 63'd2048, 14'd2);
    endtask

    task automatic test_window_extremes();
        logic [WIN_W-1:0] settings [3];
        settings[0] = '0;
        settings[1] = 32'd1;
        settings[2] = WINDOW_MAX;
        foreach (settings[k]) begin
            set_window(settings[k]);
            for (int j = 0; j < 4; j++) begin
                send_packet(63'd100 + 63'd2048 * 63'(j) + 63'(k) * 63'd8, 14'd3);
            end
            send_packet(63'd100 + 63'(k) * 63'd8, 14'd3);
            send_packet(63'd100 + 63'd2048 + 63'(k) * 63'd8, 14'd3);
        end
    endtask

    task automatic test_backpressure();
        set_window(STALE_RESET);
        stall_requests++;
        for (int j = 0; j < 40; j++) send_packet(63'd3000 + 63'd2048 * 63'(j % 4), 14'd3);
    endtask

    task automatic test_random();
        logic [ID_W-1:0]  base;
        logic [ID_W-1:0]  meas_id   [8];
        logic [TOT_W-1:0] meas_tot  [8];
        int               meas_left [8];
        int               p;
        logic [WIN_W-1:0] w;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: w = '0;
                1: w = 32'd1;
                2: w = WINDOW_MAX;
                3: w = STALE_RESET;
                4: w = $urandom_range(1, 6000);
                default: w = $urandom;
            endcase
            set_window(w);
            base = {23'b0, 32'($urandom), 8'h01};
            foreach (meas_left[k]) begin
                meas_left[k] = 0;
                meas_id[k]   = base + 63'(k);
                meas_tot[k]  = 14'd3;
            end
            for (int n = 0; n < 285; n++) begin
                case ($urandom_range(0, 9))
                    0: send_packet(ID_W'({$urandom, $urandom}),
                                   TOT_W'($urandom_range(0, 16383)));
                    1: send_packet($urandom_range(0, 1) ? '0 : ID_W'($urandom_range(1, 4095)),
                                   TOT_W'($urandom_range(0, 16383)));
                    2: send_packet(meas_id[$urandom_range(0, 7)], TOT_W'($urandom_range(0, 9)));
                    default: begin
                        p = $urandom_range(0, 7);
                        if (meas_left[p] == 0) begin
                            meas_id[p] = base + 63'($urandom_range(0, 15))
                                         + 63'd2048 * 63'($urandom_range(0, 3));
                            meas_tot[p] = TOT_W'(($urandom_range(0, 15) == 0) ?
                                          $urandom_range(9, 40) : $urandom_range(1, 6));
                            meas_left[p] = int'(meas_tot[p]);
                        end
                        send_packet(meas_id[p], meas_tot[p]);
                        meas_left[p]--;
                    end
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        pkt.valid         = 1'b0;
        pkt.packet_id     = '0;
        pkt.total_packets = '0;
        mismatches      = 0;
        packets_sent    = 0;
        tallies_checked = 0;
        windows_set     = 0;
        full_circles    = 0;
        burst_left      = 0;
        stall_requests  = 0;
        stall_served    = 0;
        foreach (slot_id_copy[k]) begin
            slot_id_copy[k]  = '0;
            slot_cnt_copy[k] = '0;
        end
        window_copy = STALE_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_window_extremes();
        test_backpressure();
        test_random();
        drain();

        $display("covered %0d packets across %0d window settings, %0d full-circle probes",
                 packets_sent, windows_set, full_circles);
        $display("compared %0d result beats, %0d mismatches", tallies_checked, mismatches);
        if (mismatches == 0) begin
            $display("probe_packet_counter_table_tb passed");
        end else begin
            $display("probe_packet_counter_table_tb failed");
        end
        $finish;
    end

endmodule
